@@ hdl/rbp_pkg.sv @@
// ----------------------------------------------------------------------------
// rbp_pkg
// Shared field widths, codes and types of the resource barrier planner.
// ----------------------------------------------------------------------------
package rbp_pkg;

  localparam int unsigned MODE_W  = 2;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TALLY_W = 8;
  localparam int unsigned TOTAL_W = 32;

  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_USE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused mode, always ignored

  localparam logic [STATE_W-1:0] ST_COMMON = 4'd0;
  localparam logic [STATE_W-1:0] ST_UAV    = 4'd6;
  localparam logic [STATE_W-1:0] ST_MAX    = 4'd8;

  localparam logic [KIND_W-1:0] KIND_NONE       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_UAV        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRANSITION = 2'd2;

  // classified item as handed from the front to the back
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] req;
    logic               present;
    logic               eop;
    logic               in_range;
  } rbp_cmd_t;

endpackage

@@ hdl/rbp_if.sv @@
// ----------------------------------------------------------------------------
// rbp_if
// Channel interfaces: input items, result items and the configuration write.
// ----------------------------------------------------------------------------
interface rbp_in_if import rbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [IDX_W-1:0]   resource_index;
  logic [STATE_W-1:0] requested_state;
  logic               resource_present;
  logic               end_of_pass;

  modport source (output valid, mode, resource_index, requested_state,
                  resource_present, end_of_pass, input ready);
  modport sink   (input valid, mode, resource_index, requested_state,
                  resource_present, end_of_pass, output ready);
endinterface

interface rbp_out_if import rbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  barrier_kind;
  logic [STATE_W-1:0] state_before;
  logic [STATE_W-1:0] state_after;
  logic [IDX_W-1:0]   barrier_resource;
  logic [TALLY_W-1:0] pass_barrier_count;
  logic [TOTAL_W-1:0] total_barriers;
  logic [TOTAL_W-1:0] total_batches;
  logic               item_ignored;

  modport source (output valid, barrier_kind, state_before, state_after,
                  barrier_resource, pass_barrier_count, total_barriers,
                  total_batches, item_ignored, input ready);
  modport sink   (input valid, barrier_kind, state_before, state_after,
                  barrier_resource, pass_barrier_count, total_barriers,
                  total_batches, item_ignored, output ready);
endinterface

interface rbp_cfg_if import rbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/rbp_front.sv @@
// ----------------------------------------------------------------------------
// rbp_front
// Holds resource_count, accepts input items and classifies them for the back.
// ----------------------------------------------------------------------------
module rbp_front import rbp_pkg::*; #(
  parameter int unsigned RESOURCE_SLOTS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rbp_in_if.sink   in_i,
  rbp_cfg_if.sink  cfg_i,
  output logic     push_valid_o,
  input  logic     push_ready_i,
  output rbp_cmd_t push_cmd_o
);

  logic [COUNT_W-1:0] count_q;
  logic               in_range;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.data;
    end
  end

  assign in_range = ({1'b0, in_i.resource_index} < count_q) &&
                    (32'(in_i.resource_index) < 32'(RESOURCE_SLOTS));

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  always_comb begin
    push_cmd_o.mode     = in_i.mode;
    push_cmd_o.idx      = in_i.resource_index;
    // unknown state codes fold to common
    push_cmd_o.req      = (in_i.requested_state > ST_MAX) ? ST_COMMON
                                                          : in_i.requested_state;
    push_cmd_o.present  = in_i.resource_present;
    push_cmd_o.eop      = in_i.end_of_pass;
    push_cmd_o.in_range = in_range;
  end

endmodule

@@ hdl/rbp_queue.sv @@
// ----------------------------------------------------------------------------
// rbp_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module rbp_queue import rbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  rbp_cmd_t push_cmd_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output rbp_cmd_t pop_cmd_o
);

  rbp_cmd_t   entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop)      fill_q <= fill_q + 2'd1;
      else if (pop && !push) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

@@ hdl/rbp_back.sv @@
// ----------------------------------------------------------------------------
// rbp_back
// State table read-modify-write, barrier counters and the result register.
// ----------------------------------------------------------------------------
module rbp_back import rbp_pkg::*; #(
  parameter int unsigned RESOURCE_SLOTS = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     pop_valid_i,
  output logic     pop_ready_o,
  input  rbp_cmd_t pop_cmd_i,
  rbp_out_if.source out_o
);

  // only indices the input field can name are stored
  localparam int unsigned DEPTH = (RESOURCE_SLOTS < (2 ** IDX_W)) ? RESOURCE_SLOTS
                                                                 : (2 ** IDX_W);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic               state_q;
  rbp_cmd_t           cmd_q;
  logic [STATE_W-1:0] tbl_q [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [STATE_W-1:0] rd_data_q;
  logic               rd_vld_q;
  logic [AW-1:0]      rd_addr, wr_addr;

  logic [TALLY_W-1:0] tally_q;
  logic [TOTAL_W-1:0] barriers_q, batches_q;

  logic               out_valid_q;
  logic [KIND_W-1:0]  kind_q;
  logic [STATE_W-1:0] before_q, after_q;
  logic [IDX_W-1:0]   res_q;
  logic [TALLY_W-1:0] count_out_q;
  logic               ignored_q;

  logic               pop;
  logic [STATE_W-1:0] tracked, prior, after;
  logic [KIND_W-1:0]  kind;
  logic               ignored, wr_en, barrier, active;
  logic [TALLY_W-1:0] tally_new;
  logic [TOTAL_W-1:0] barriers_new;

  // the result register is free at the execute step whenever a pop was allowed
  assign pop_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign pop         = pop_valid_i && pop_ready_o;
  assign rd_addr     = pop_cmd_i.idx[AW-1:0];
  assign wr_addr     = cmd_q.idx[AW-1:0];

  always_comb begin
    tracked = rd_vld_q ? rd_data_q : ST_COMMON;
    active  = cmd_q.in_range && (cmd_q.mode != MODE_SPARE);
    prior   = active ? tracked : ST_COMMON;
    after   = prior;
    kind    = KIND_NONE;
    ignored = !active;
    wr_en   = 1'b0;
    barrier = 1'b0;
    if (active) begin
      case (cmd_q.mode)
        MODE_INIT: begin
          after = cmd_q.req;
          wr_en = 1'b1;
        end
        MODE_USE: begin
          if (!cmd_q.present) begin
            ignored = 1'b1;
          end else if (tracked == cmd_q.req) begin
            if (cmd_q.req == ST_UAV) begin
              kind    = KIND_UAV;
              barrier = 1'b1;
            end
          end else begin
            kind    = KIND_TRANSITION;
            after   = cmd_q.req;
            wr_en   = 1'b1;
            barrier = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    tally_new    = (barrier && tally_q != '1) ? tally_q + 1'b1 : tally_q;
    barriers_new = (barrier && barriers_q != '1) ? barriers_q + 1'b1 : barriers_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
      tally_q     <= '0;
      barriers_q  <= '0;
      batches_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (out_o.ready) out_valid_q <= 1'b0;
          if (pop) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
          if (wr_en) vld_q[wr_addr] <= 1'b1;
          barriers_q <= barriers_new;
          if (cmd_q.eop) begin
            if (tally_new != '0 && batches_q != '1) batches_q <= batches_q + 1'b1;
            tally_q <= '0;
          end else begin
            tally_q <= tally_new;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cmd_q     <= pop_cmd_i;
      rd_data_q <= tbl_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
    end
    if (state_q == S_EXEC) begin
      if (wr_en) tbl_q[wr_addr] <= after;
      kind_q      <= kind;
      before_q    <= prior;
      after_q     <= after;
      res_q       <= cmd_q.idx;
      count_out_q <= tally_new;
      ignored_q   <= ignored;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.barrier_kind       = kind_q;
  assign out_o.state_before       = before_q;
  assign out_o.state_after        = after_q;
  assign out_o.barrier_resource   = res_q;
  assign out_o.pass_barrier_count = count_out_q;
  assign out_o.total_barriers     = barriers_q;
  assign out_o.total_batches      = batches_q;
  assign out_o.item_ignored       = ignored_q;

endmodule

@@ hdl/resource_barrier_planner.sv @@
// ----------------------------------------------------------------------------
// resource_barrier_planner
// Tracks the access state of each resource and plans barriers per usage.
// ----------------------------------------------------------------------------
// Channels: in_i takes one item (mode, index, requested state, presence,
// end-of-pass mark); out_o gives exactly one result item per input item, in
// order. cfg_i writes resource_count and is always ready; write it only while
// the block is idle.
// Flow: an accepted item sits in the two-entry queue, is popped with its
// table entry read into a register, and its result is registered in the
// back end's execute step.
// Pacing: the back end pops an item only after the execute step of the last,
// alternating read and execute steps on the single-port state table.
// Reset: all tracked states read as common (per-entry valid bits are
// cleared), counters and resource_count go to zero; no clearing pass.
// Stall: a result holds in the output register while out_o.ready is low; the
// back end stops popping and the queue fills, after which in_i.ready drops.
// ----------------------------------------------------------------------------
module resource_barrier_planner import rbp_pkg::*; #(
  parameter int unsigned RESOURCE_SLOTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbp_in_if.sink    in_i,
  rbp_cfg_if.sink   cfg_i,
  rbp_out_if.source out_o
);

  logic     push_valid, push_ready, pop_valid, pop_ready;
  rbp_cmd_t push_cmd, pop_cmd;

  rbp_front #(
    .RESOURCE_SLOTS(RESOURCE_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd)
  );

  rbp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  rbp_back #(
    .RESOURCE_SLOTS(RESOURCE_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_cmd_i  (pop_cmd),
    .out_o      (out_o)
  );

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for resource_barrier_planner. A table of directed items
// is followed by random passes at several resource counts and a long pass
// that saturates the per-pass tally. The bench keeps its own state table and
// counters, works out each result as its item is accepted, and compares every
// result field against the oldest pending one. Both sides stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rbp_pkg::*;

  localparam int unsigned IDLE_LIMIT = 500;
  localparam int unsigned SLOTS = 64;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] req;
    logic               present;
    logic               eop;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] prior;
    logic [STATE_W-1:0] after;
    logic [IDX_W-1:0]   res;
    logic [TALLY_W-1:0] tally;
    logic [TOTAL_W-1:0] barriers;
    logic [TOTAL_W-1:0] batches;
    logic               ignored;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_act_e;

  // typed = 1: kind/prior/after/ignored are taken from the row, not predicted
  typedef struct packed {
    row_act_e           act;
    logic [COUNT_W-1:0] cfg_value;
    logic [MODE_W-1:0]  mode;
    logic [IDX_W-1:0]   idx;
    logic [STATE_W-1:0] req;
    logic               present;
    logic               eop;
    logic               typed;
    logic [KIND_W-1:0]  kind;
    logic [STATE_W-1:0] prior;
    logic [STATE_W-1:0] after;
    logic               ignored;
  } row_t;

  localparam int unsigned NUM_ROWS = 25;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    // resource_count 0 after reset: everything is out of range
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd0,  4'd1,  1'b1, 1'b0, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b1},
    '{ROW_CFG,  7'd64,  MODE_INIT,  6'd0,  4'd0,  1'b0, 1'b0, 1'b0, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_READ,  6'd63, 4'd0,  1'b1, 1'b0, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd0,  4'd0,  1'b1, 1'b0, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd0,  4'd6,  1'b1, 1'b0, 1'b1,
      KIND_TRANSITION, 4'd0, 4'd6, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd0,  4'd6,  1'b1, 1'b0, 1'b1, KIND_UAV, 4'd6, 4'd6, 1'b0},
    // request above copy dst falls back to common
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd0,  4'd15, 1'b1, 1'b0, 1'b1,
      KIND_TRANSITION, 4'd6, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_INIT,  6'd63, 4'd8,  1'b1, 1'b0, 1'b1, KIND_NONE, 4'd0, 4'd8, 1'b0},
    // absent resource on a usage: ignored, states shown
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd63, 4'd8,  1'b0, 1'b0, 1'b1, KIND_NONE, 4'd8, 4'd8, 1'b1},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd63, 4'd7,  1'b1, 1'b1, 1'b1,
      KIND_TRANSITION, 4'd8, 4'd7, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_SPARE, 6'd5,  4'd4,  1'b1, 1'b0, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b1},
    '{ROW_ITEM, 7'd0,   MODE_SPARE, 6'd5,  4'd4,  1'b1, 1'b1, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b1},
    // presence not looked at for init and read
    '{ROW_ITEM, 7'd0,   MODE_INIT,  6'd5,  4'd9,  1'b0, 1'b0, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_READ,  6'd63, 4'd15, 1'b0, 1'b0, 1'b1, KIND_NONE, 4'd7, 4'd7, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd1,  4'd1,  1'b1, 1'b0, 1'b0, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd2,  4'd2,  1'b1, 1'b1, 1'b0, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd2,  4'd3,  1'b1, 1'b1, 1'b0, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_CFG,  7'd1,   MODE_INIT,  6'd0,  4'd0,  1'b0, 1'b0, 1'b0, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd1,  4'd3,  1'b1, 1'b0, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b1},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd0,  4'd4,  1'b1, 1'b1, 1'b1,
      KIND_TRANSITION, 4'd0, 4'd4, 1'b0},
    '{ROW_CFG,  7'd127, MODE_INIT,  6'd0,  4'd0,  1'b0, 1'b0, 1'b0, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd63, 4'd6,  1'b1, 1'b0, 1'b1,
      KIND_TRANSITION, 4'd7, 4'd6, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_USE,   6'd63, 4'd6,  1'b1, 1'b0, 1'b1, KIND_UAV, 4'd6, 4'd6, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_INIT,  6'd62, 4'd15, 1'b1, 1'b1, 1'b1, KIND_NONE, 4'd0, 4'd0, 1'b0},
    '{ROW_ITEM, 7'd0,   MODE_READ,  6'd0,  4'd0,  1'b0, 1'b1, 1'b1, KIND_NONE, 4'd4, 4'd4, 1'b0}
  };

  logic clk;
  logic rst_ni;

  rbp_in_if  in_ch ();
  rbp_out_if out_ch ();
  rbp_cfg_if cfg_ch ();

  resource_barrier_planner uut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .cfg_i  (cfg_ch.sink),
    .out_o  (out_ch.source)
  );

  // bench copy of the block state
  logic [STATE_W-1:0] tracked [SLOTS];
  logic [TALLY_W-1:0] pass_tally;
  logic [TOTAL_W-1:0] barrier_sum;
  logic [TOTAL_W-1:0] batch_sum;
  logic [COUNT_W-1:0] active_count;

  result_t     pending_results [$];
  int unsigned errors;
  int unsigned idle_cycles;
  bit          in_burst;
  bit          out_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void count_barrier();
    if (pass_tally != '1) pass_tally++;
    if (barrier_sum != '1) barrier_sum++;
  endfunction

  function automatic result_t plan_barrier(item_t it);
    result_t            r;
    logic [STATE_W-1:0] req;
    logic               in_range;
    r        = '0;
    r.res    = it.idx;
    req      = (it.req > ST_MAX) ? ST_COMMON : it.req;
    in_range = ({1'b0, it.idx} < active_count);
    if (it.mode == MODE_SPARE || !in_range) begin
      r.ignored = 1'b1;
    end else begin
      r.prior = tracked[it.idx];
      r.after = r.prior;
      case (it.mode)
        MODE_INIT: begin
          tracked[it.idx] = req;
          r.after = req;
        end
        MODE_USE: begin
          if (!it.present) begin
            r.ignored = 1'b1;
          end else if (r.prior == req) begin
            if (req == ST_UAV) begin
              r.kind = KIND_UAV;
              count_barrier();
            end
          end else begin
            r.kind = KIND_TRANSITION;
            tracked[it.idx] = req;
            r.after = req;
            count_barrier();
          end
        end
        default: ;
      endcase
    end
    r.tally = pass_tally;
    if (it.eop) begin
      if (pass_tally != 0 && batch_sum != '1) batch_sum++;
      pass_tally = '0;
    end
    r.barriers = barrier_sum;
    r.batches  = batch_sum;
    return r;
  endfunction

  // the stimulus tasks below start and end at a falling edge
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_resource_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    repeat (4) @(negedge clk);
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    active_count = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic push_item(input item_t it, input bit typed, input result_t typed_r);
    int unsigned gap;
    result_t     r;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode             = it.mode;
    in_ch.resource_index   = it.idx;
    in_ch.requested_state  = it.req;
    in_ch.resource_present = it.present;
    in_ch.end_of_pass      = it.eop;
    in_ch.valid            = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    r = plan_barrier(it);
    if (typed) begin
      r.kind    = typed_r.kind;
      r.prior   = typed_r.prior;
      r.after   = typed_r.after;
      r.ignored = typed_r.ignored;
    end
    pending_results = {pending_results, r};
    @(negedge clk);
  endtask

  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    if (pick < 55)      it.mode = MODE_USE;
    else if (pick < 72) it.mode = MODE_INIT;
    else if (pick < 92) it.mode = MODE_READ;
    else                it.mode = MODE_SPARE;
    span = (active_count > SLOTS) ? SLOTS : active_count;
    pick = $urandom_range(0, 99);
    // a small working set makes repeated requests on one resource common
    if (span == 0 || pick >= 90) it.idx = IDX_W'($urandom_range(0, SLOTS - 1));
    else if (pick < 50)          it.idx = IDX_W'($urandom_range(0, (span < 4 ? span : 4) - 1));
    else                         it.idx = IDX_W'($urandom_range(0, span - 1));
    pick = $urandom_range(0, 99);
    if (pick < 20)      it.req = ST_UAV;
    else if (pick < 90) it.req = STATE_W'($urandom_range(0, ST_MAX));
    else                it.req = STATE_W'($urandom_range(0, 15));
    it.present = ($urandom_range(0, 9) != 0);
    it.eop     = ($urandom_range(0, 7) == 0);
    return it;
  endfunction

  task automatic run_random(input logic [COUNT_W-1:0] count, input int unsigned n_items,
                            input bit hold_mid);
    write_resource_count(count);
    for (int unsigned k = 0; k < n_items; k++) begin
      if ((hold_mid && k == n_items / 2) || $urandom_range(0, 59) == 0) wait_drained();
      push_item(random_item(), 1'b0, '0);
    end
  endtask

  // every usage causes a barrier and the pass stays open: drives the tally to 255
  task automatic run_long_pass(input int unsigned n_items);
    item_t it;
    write_resource_count(7'd64);
    for (int unsigned k = 0; k < n_items; k++) begin
      it.mode    = MODE_USE;
      it.idx     = IDX_W'($urandom_range(0, SLOTS - 1));
      it.req     = STATE_W'($urandom_range(0, ST_MAX));
      if (it.req == tracked[it.idx] && it.req != ST_UAV)
        it.req = (it.req == ST_MAX) ? ST_COMMON : it.req + 1'b1;
      it.present = 1'b1;
      it.eop     = (k == n_items - 1);
      push_item(it, 1'b0, '0);
    end
  endtask

  // result side: random stall before each result, with stall-free stretches
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    out_burst    = 1'b0;
    @(posedge rst_ni);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      stall = out_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] exp_v,
                             input logic [TOTAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual resource %0d", $time,
                 out_ch.barrier_resource);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("barrier_kind", TOTAL_W'(exp_r.kind), TOTAL_W'(out_ch.barrier_kind));
        check_field("state_before", TOTAL_W'(exp_r.prior), TOTAL_W'(out_ch.state_before));
        check_field("state_after", TOTAL_W'(exp_r.after), TOTAL_W'(out_ch.state_after));
        check_field("barrier_resource", TOTAL_W'(exp_r.res),
                    TOTAL_W'(out_ch.barrier_resource));
        check_field("pass_barrier_count", TOTAL_W'(exp_r.tally),
                    TOTAL_W'(out_ch.pass_barrier_count));
        check_field("total_barriers", exp_r.barriers, out_ch.total_barriers);
        check_field("total_batches", exp_r.batches, out_ch.total_batches);
        check_field("item_ignored", TOTAL_W'(exp_r.ignored), TOTAL_W'(out_ch.item_ignored));
      end
    end
  end

  // watchdog: cycles in a row with no handshake on any channel
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    result_t typed_r;
    item_t   it;
    errors       = 0;
    idle_cycles  = 0;
    in_burst     = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = MODE_INIT;
    in_ch.resource_index   = '0;
    in_ch.requested_state  = ST_COMMON;
    in_ch.resource_present = 1'b0;
    in_ch.end_of_pass      = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    for (int i = 0; i < SLOTS; i++) tracked[i] = ST_COMMON;
    pass_tally   = '0;
    barrier_sum  = '0;
    batch_sum    = '0;
    active_count = '0;
    repeat (9) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (DIRECTED[i].act == ROW_CFG) begin
        write_resource_count(DIRECTED[i].cfg_value);
      end else begin
        it.mode         = DIRECTED[i].mode;
        it.idx          = DIRECTED[i].idx;
        it.req          = DIRECTED[i].req;
        it.present      = DIRECTED[i].present;
        it.eop          = DIRECTED[i].eop;
        typed_r         = '0;
        typed_r.kind    = DIRECTED[i].kind;
        typed_r.prior   = DIRECTED[i].prior;
        typed_r.after   = DIRECTED[i].after;
        typed_r.ignored = DIRECTED[i].ignored;
        push_item(it, DIRECTED[i].typed, typed_r);
      end
    end

    run_random(7'd64, 60, 1'b0);
    run_random(7'd1, 15, 1'b0);
    run_random(7'd0, 10, 1'b0);
    run_random(7'd127, 50, 1'b1);
    run_long_pass(270);
    run_random(7'd17, 25, 1'b0);

    wait_drained();
    repeat (8) @(posedge clk);
    errors += pending_results.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rbp_pkg.sv
hdl/rbp_if.sv
hdl/rbp_front.sv
hdl/rbp_queue.sv
hdl/rbp_back.sv
hdl/resource_barrier_planner.sv
tb/testbench.sv
